>>> src/ffra_pkg.sv
package ffra_pkg;

  localparam int unsigned MaxRegions = 64;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned IdxW       = $clog2(MaxRegions);
  localparam int unsigned CntW       = $clog2(MaxRegions + 1);
  localparam int unsigned TotalW     = 21;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StBadKind = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic [1:0] KindInvalid = 2'd3;

  localparam logic [0:0] RegWinStart = 1'b0;
  localparam logic [0:0] RegWinEnd   = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, check it
    logic rd_first;  // issue read of head entry
    logic rd_next;   // issue read of next entry
    logic check;     // read data valid: evaluate gap
    logic check_last; // evaluate trailing gap
    logic link_rd;   // read link of predecessor
    logic commit;    // write region, update head/links/total
    logic fail;      // deliver failure result
  } ffra_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic early_done; // bad kind/full/overflow/empty resolved
    logic found;
    logic walk_end;   // current entry is the last one
  } ffra_sts_t;

endpackage

>>> src/ffra_ctrl.sv
module ffra_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  input  ffra_pkg::ffra_sts_t sts_i,
  output ffra_pkg::ffra_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    Idle, Eval, Wait, Check, Link, Commit, Out
  } state_e;

  state_e state_q;
  logic   ok_q;

  assign in_stall_o = (state_q != Idle);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      Idle:   cmd_o.load = in_valid_i;
      Eval:   cmd_o.rd_first = !sts_i.early_done;
      Wait:   ;
      Check: begin
        cmd_o.check      = 1'b1;
        cmd_o.check_last = sts_i.walk_end;
        cmd_o.rd_next    = 1'b1;
      end
      Link:   cmd_o.link_rd = 1'b1;
      Commit: begin
        cmd_o.commit = ok_q;
        cmd_o.fail   = !ok_q;
      end
      Out:    ;
      default: ;
    endcase
  end

  // sequencer: state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      ok_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        Idle: if (in_valid_i) state_q <= Eval;
        Eval: begin
          if (sts_i.early_done) begin
            ok_q    <= sts_i.found;
            state_q <= sts_i.found ? Link : Commit;
          end else begin
            state_q <= Wait;
          end
        end
        Wait: state_q <= Check;
        Check: begin
          if (sts_i.found) begin
            ok_q <= 1'b1; state_q <= Link;
          end else if (sts_i.walk_end) begin
            ok_q <= 1'b0; state_q <= Commit;
          end else begin
            state_q <= Wait;
          end
        end
        Link: state_q <= Commit;
        Commit: begin
          out_valid_o <= 1'b1;
          state_q     <= Out;
        end
        Out: if (!out_stall_i) begin
          out_valid_o <= 1'b0;
          state_q     <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

endmodule

>>> src/ffra_dp.sv
module ffra_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [31:0]                  win_start_i,
  input  logic [31:0]                  win_end_i,
  input  logic [31:0]                  request_bytes_i,
  input  logic [1:0]                   mapping_kind_i,
  input  ffra_pkg::ffra_cmd_t          cmd_i,
  output ffra_pkg::ffra_sts_t          sts_o,
  output logic [31:0]                  granted_address_o,
  output logic [1:0]                   status_o,
  output logic [ffra_pkg::TotalW-1:0]  pages_in_use_o
);

  localparam int unsigned IdxW = ffra_pkg::IdxW;
  localparam int unsigned CntW = ffra_pkg::CntW;

  // region table: start, size, link in memories (kind is stored only)
  logic [31:0]     mem_start [ffra_pkg::MaxRegions];
  logic [31:0]     mem_size  [ffra_pkg::MaxRegions];
  logic [1:0]      mem_kind  [ffra_pkg::MaxRegions];
  logic [IdxW-1:0] mem_link  [ffra_pkg::MaxRegions];

  logic [IdxW-1:0] head_q;
  logic [CntW-1:0] count_q;
  logic [ffra_pkg::TotalW-1:0] total_q;

  logic [32:0]     size_q;
  logic [1:0]      kind_q;
  logic [32:0]     prev_end_q;   // end of entry before the one being read
  logic [IdxW-1:0] prev_q;       // index of that entry
  logic            has_prev_q;
  logic [IdxW-1:0] rd_addr;
  logic            rd_en;
  logic [31:0]     rd_start_q, rd_size_q;
  logic [IdxW-1:0] rd_link_q, rd_idx_q;
  logic [CntW-1:0] seen_q;       // entries read so far
  logic [31:0]     addr_q;
  logic            hit_q;
  logic [IdxW-1:0] prev_link_q;

  // rounding to pages, 33 bits so overflow shows
  logic [32:0] size_rnd;
  assign size_rnd = ({1'b0, request_bytes_i} + 33'((1 << ffra_pkg::PageShift) - 1))
                    & ~33'((1 << ffra_pkg::PageShift) - 1);

  // early checks at Eval, using latched request
  logic        bad_kind, full, ovf, empty_fit;
  assign bad_kind  = (kind_q == ffra_pkg::KindInvalid);
  assign full      = (count_q >= CntW'(ffra_pkg::MaxRegions));
  assign ovf       = size_q[32];
  assign empty_fit = ({1'b0, win_start_i} + size_q) <= {1'b0, win_end_i};

  // gap checks on read data
  logic [32:0] cur_end, gap_lo, gap_hi, gap_sz;
  logic        gap_ok, tail_ok, walk_end;
  assign cur_end  = {1'b0, rd_start_q} + {1'b0, rd_size_q};
  assign gap_lo   = has_prev_q ? prev_end_q : {1'b0, win_start_i};
  assign gap_hi   = {1'b0, rd_start_q};
  assign gap_sz   = gap_hi - gap_lo;
  // a closed gap between two regions still takes a zero-size request
  assign gap_ok   = (gap_hi > gap_lo) ? (gap_sz >= size_q)
                                      : (has_prev_q && (size_q == '0));
  assign tail_ok  = (cur_end < {1'b0, win_end_i}) &&
                    (({1'b0, win_end_i} - cur_end) >= size_q);
  assign walk_end = (seen_q == count_q);

  always_comb begin
    sts_o = '0;
    if (cmd_i.check) begin
      sts_o.found    = gap_ok || (walk_end && tail_ok);
      sts_o.walk_end = walk_end;
    end else begin
      sts_o.early_done = bad_kind || full || ovf || (count_q == '0);
      sts_o.found      = !bad_kind && !full && !ovf && (count_q == '0) && empty_fit;
    end
  end

  assign rd_en   = cmd_i.rd_first || (cmd_i.rd_next && !sts_o.found && !walk_end);
  assign rd_addr = cmd_i.rd_first ? head_q : rd_link_q;

  // table reads, registered
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_start_q <= mem_start[rd_addr];
      rd_size_q  <= mem_size[rd_addr];
      rd_link_q  <= mem_link[rd_addr];
      rd_idx_q   <= rd_addr;
    end
    if (cmd_i.link_rd) prev_link_q <= mem_link[prev_q];
    if (cmd_i.commit) begin
      mem_start[count_q[IdxW-1:0]] <= addr_q;
      mem_size[count_q[IdxW-1:0]]  <= size_q[31:0];
      mem_kind[count_q[IdxW-1:0]]  <= kind_q;
      if (count_q == '0 || !has_prev_q) begin
        mem_link[count_q[IdxW-1:0]] <= (count_q == '0) ? '0 : head_q;
      end else begin
        mem_link[count_q[IdxW-1:0]] <= prev_link_q;
        mem_link[prev_q]            <= count_q[IdxW-1:0];
      end
    end
  end

  // request and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q     <= size_rnd;
      kind_q     <= mapping_kind_i;
      has_prev_q <= 1'b0;
      hit_q      <= 1'b0;
      addr_q     <= win_start_i;
      seen_q     <= '0;
    end
    if (cmd_i.rd_first) seen_q <= CntW'(1);
    if (cmd_i.check) begin
      if (gap_ok) begin
        addr_q <= gap_lo[31:0];
      end else begin
        has_prev_q <= 1'b1;
        prev_q     <= rd_idx_q;
        prev_end_q <= cur_end;
        addr_q     <= cur_end[31:0];
        if (!walk_end) seen_q <= seen_q + CntW'(1);
      end
    end
    if (cmd_i.commit) hit_q <= 1'b1;
    if (cmd_i.fail)   hit_q <= 1'b0;
    if (cmd_i.commit || cmd_i.fail) begin
      priority if (cmd_i.fail && bad_kind) status_o <= ffra_pkg::StBadKind;
      else if (cmd_i.fail && full)         status_o <= ffra_pkg::StFull;
      else if (cmd_i.fail)                 status_o <= ffra_pkg::StNoSpace;
      else                                 status_o <= ffra_pkg::StOk;
    end
  end

  assign granted_address_o = hit_q ? addr_q : '0;
  assign pages_in_use_o    = total_q;

  // control state of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      total_q <= '0;
    end else if (cmd_i.commit) begin
      if (count_q == '0 || !has_prev_q) head_q <= count_q[IdxW-1:0];
      count_q <= count_q + CntW'(1);
      total_q <= total_q + ffra_pkg::TotalW'(size_q[31:ffra_pkg::PageShift]);
    end
  end

endmodule

>>> src/first_fit_range_allocator.sv
// First-fit address range allocator.
// Request channel: request_bytes_i, mapping_kind_i with req_valid_i/req_stall_o.
// Result channel: granted_address_o, status_o, pages_in_use_o with
// rsp_valid_o/rsp_stall_i; exactly one result transfer per request.
// The APB port sets window_start (0x0) and window_end (0x4); the user must
// write them only while idle, which the block leaves to the user. One request
// at a time. A request ends early on a failing check (bad kind, full table,
// size overflow, no fit in an empty window) or on a grant into an empty
// table; otherwise a walk visits table entries, each by a registered table
// read, then a gap check (a table of 64 entries is refused as full). The walk
// through the linked table memory sets how long a request takes.
// The result stays in its register until taken; req_stall_o stays high until
// the result transfer, so a stalled receiver holds off new requests.
// Reset empties the table, clears the page total and the window registers.
module first_fit_range_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [31:0] request_bytes_i,
  input  logic [1:0]  mapping_kind_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o,
  output logic [20:0] pages_in_use_o
);

  logic [31:0] win_start_q, win_end_q;
  ffra_pkg::ffra_cmd_t cmd;
  ffra_pkg::ffra_sts_t sts;

  assign pready = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '0;
    end else if (psel && penable && pwrite && paddr[2] == ffra_pkg::RegWinStart) begin
      win_start_q <= pwdata;
    end else if (psel && penable && pwrite) begin
      win_end_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == ffra_pkg::RegWinEnd) ? win_end_q : win_start_q;

  ffra_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_valid_i),
    .in_stall_o (req_stall_o),
    .out_stall_i(rsp_stall_i),
    .out_valid_o(rsp_valid_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffra_dp u_dp (
    .clk_i, .rst_ni,
    .win_start_i      (win_start_q),
    .win_end_i        (win_end_q),
    .request_bytes_i,
    .mapping_kind_i,
    .cmd_i            (cmd),
    .sts_o            (sts),
    .granted_address_o,
    .status_o,
    .pages_in_use_o
  );

  // no new request while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o) else $error("request taken while result pending");

  // failed results carry address zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && status_o != ffra_pkg::StOk) |-> granted_address_o == '0)
    else $error("nonzero address on failure");

  // total only moves on a grant
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.commit |=> $stable(pages_in_use_o)) else $error("page total moved");

endmodule
